// ===== hw/rtl/mnp_pkg.sv =====
// mnp_pkg: shared types and codes for the midi note pairing block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mnp_pkg;

   // event kinds
   localparam logic [1:0] ModeNoteOn  = 2'd0;
   localparam logic [1:0] ModeNoteOff = 2'd1;
   localparam logic [1:0] ModeDamper  = 2'd2;

   // result status codes
   localparam logic [2:0] StatusNoteDone   = 3'd0;
   localparam logic [2:0] StatusDamperDone = 3'd1;
   localparam logic [2:0] StatusOffNoOn    = 3'd2;
   localparam logic [2:0] StatusLiftNoPress = 3'd3;
   localparam logic [2:0] StatusBadDamper  = 3'd4;

   // damper pedal values
   localparam logic [6:0] PedalRelease = 7'd0;
   localparam logic [6:0] PedalPress   = 7'd1;

   localparam logic [31:0] TickMax = 32'hFFFF_FFFF;

   // queue between front and back
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // one classified request with its absolute tick
   typedef struct packed {
      logic [1:0]  mode;
      logic [6:0]  pitch;
      logic [6:0]  vel;
      logic [31:0] tick;
   } event_type;

   // one result item
   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  pitch;
      logic [6:0]  vel;
      logic [31:0] start;
      logic [31:0] stop;
   } result_type;

   // one open-note table entry payload
   typedef struct packed {
      logic [6:0]  vel;
      logic [31:0] start;
   } slot_type;

endpackage

// ===== hw/rtl/mnp_front.sv =====
// mnp_front: accepts requests and stamps each with the saturating running tick
// depends on mnp_pkg
`timescale 1ns / 1ps

module mnp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [27:0]        req_delta_ticks,
   input  logic [6:0]         req_pitch_or_pedal,
   input  logic [6:0]         req_velocity,
   output logic               push_valid,
   input  logic               push_ready,
   output mnp_pkg::event_type push_evt
);
   import mnp_pkg::*;

   logic [31:0] tick_ff;
   logic [31:0] tick_in;
   logic [32:0] tick_sum;
   logic        accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   // saturating add of the delta
   assign tick_sum = {1'b0, tick_ff} + 33'(req_delta_ticks);
   assign tick_in  = tick_sum[32] ? TickMax : tick_sum[31:0];

   assign push_evt.mode  = req_mode;
   assign push_evt.pitch = req_pitch_or_pedal;
   assign push_evt.vel   = req_velocity;
   assign push_evt.tick  = tick_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else if (accept) begin
         tick_ff <= tick_in;
      end
   end

endmodule

// ===== hw/rtl/mnp_queue.sv =====
// mnp_queue: short fifo of stamped events between front and back
// depends on mnp_pkg
`timescale 1ns / 1ps

module mnp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  mnp_pkg::event_type push_evt,
   output logic               pop_valid,
   input  logic               pop_ready,
   output mnp_pkg::event_type pop_evt
);
   import mnp_pkg::*;

   event_type              slot_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff;
   logic [QueuePtrW-1:0]   rd_ptr_ff;
   logic [QueueCntW-1:0]   count_ff;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = count_ff != QueueCntW'(QueueDepth);
   assign pop_valid  = count_ff != '0;
   assign pop_evt    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_evt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hw/rtl/mnp_back.sv =====
// mnp_back: open-note table, damper record and result register
// depends on mnp_pkg; takes events from mnp_queue
`timescale 1ns / 1ps

module mnp_back #(
   parameter int PITCH_COUNT = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  mnp_pkg::event_type  pop_evt,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mnp_pkg::result_type rsp_res
);
   import mnp_pkg::*;

   localparam int IdxW = $clog2(PITCH_COUNT);
   localparam logic [7:0] PitchLimit = 8'(PITCH_COUNT);

   localparam logic StLook = 1'b0;
   localparam logic StExec = 1'b1;

   logic                   state_ff;
   event_type              work_ff;
   slot_type               rd_ff;
   slot_type               mem [PITCH_COUNT];
   logic [PITCH_COUNT-1:0] open_ff;
   logic                   pedal_down_ff;
   logic [31:0]            pedal_start_ff;
   logic                   halted_ff;
   logic                   rsp_valid_ff;
   result_type             rsp_ff;

   logic [IdxW-1:0] rd_idx;
   logic [IdxW-1:0] wk_idx;
   logic            in_range;
   logic            open_hit;
   logic            out_free;
   logic            need_out;
   logic            commit;
   logic            emit;
   logic            set_open;
   logic            clr_open;
   logic            halt_set;
   logic            pedal_set;
   logic            pedal_clr;
   result_type      res;

   assign rd_idx    = pop_evt.pitch[IdxW-1:0];
   assign wk_idx    = work_ff.pitch[IdxW-1:0];
   assign pop_ready = state_ff == StLook;
   assign in_range  = {1'b0, work_ff.pitch} < PitchLimit;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      open_hit = 1'b0;
      if (in_range) begin
         open_hit = open_ff[wk_idx];
      end
   end

   // decide what the event in the execute slot does
   always_comb begin
      need_out  = 1'b0;
      set_open  = 1'b0;
      clr_open  = 1'b0;
      halt_set  = 1'b0;
      pedal_set = 1'b0;
      pedal_clr = 1'b0;
      res       = '0;
      if (!halted_ff) begin
         unique case (work_ff.mode)
            ModeNoteOn: begin
               set_open = in_range;
            end
            ModeNoteOff: begin
               need_out = 1'b1;
               if (open_hit) begin
                  clr_open   = 1'b1;
                  res.status = StatusNoteDone;
                  res.pitch  = work_ff.pitch;
                  res.vel    = rd_ff.vel;
                  res.start  = rd_ff.start;
                  res.stop   = work_ff.tick;
               end else begin
                  halt_set   = 1'b1;
                  res.status = StatusOffNoOn;
               end
            end
            ModeDamper: begin
               priority if (work_ff.pitch == PedalRelease && !pedal_down_ff) begin
                  need_out   = 1'b1;
                  halt_set   = 1'b1;
                  res.status = StatusLiftNoPress;
               end else if (work_ff.pitch == PedalPress && !pedal_down_ff) begin
                  pedal_set = 1'b1;
               end else if (work_ff.pitch == PedalRelease && pedal_down_ff) begin
                  need_out   = 1'b1;
                  pedal_clr  = 1'b1;
                  res.status = StatusDamperDone;
                  res.start  = pedal_start_ff;
                  res.stop   = work_ff.tick;
               end else begin
                  need_out   = 1'b1;
                  halt_set   = 1'b1;
                  res.status = StatusBadDamper;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // a result waits in execute until the output register is free
   assign commit = (state_ff == StExec) && (!need_out || out_free);
   assign emit   = commit && need_out;

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         work_ff <= pop_evt;
         rd_ff   <= mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (commit && set_open) begin
         mem[wk_idx] <= '{vel: work_ff.vel, start: work_ff.tick};
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= res;
      end
      if (commit && pedal_set) begin
         pedal_start_ff <= work_ff.tick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StLook;
         open_ff       <= '0;
         pedal_down_ff <= 1'b0;
         halted_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (state_ff == StLook) begin
            if (pop_valid) begin
               state_ff <= StExec;
            end
         end else if (commit) begin
            state_ff <= StLook;
         end
         if (commit && set_open) begin
            open_ff[wk_idx] <= 1'b1;
         end
         if (commit && clr_open) begin
            open_ff[wk_idx] <= 1'b0;
         end
         if (commit && pedal_set) begin
            pedal_down_ff <= 1'b1;
         end
         if (commit && pedal_clr) begin
            pedal_down_ff <= 1'b0;
         end
         if (commit && halt_set) begin
            halted_ff <= 1'b1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_res   = rsp_ff;

   // halt holds until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag dropped without reset");

   // an error result always halts the block
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      (emit && res.status != StatusNoteDone && res.status != StatusDamperDone)
      |=> halted_ff)
      else $error("error result without halt");

   // a new result only comes out of the execute step
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == StExec))
      else $error("result raised outside execute");

   // a popped event always goes to execute next
   a_pop_to_exec: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> state_ff == StExec)
      else $error("pop did not enter execute");

endmodule

// ===== hw/rtl/midi_note_pairing.sv =====
// midi_note_pairing: top level of the midi note on/off pairing block
// depends on mnp_pkg, mnp_front, mnp_queue and mnp_back
`timescale 1ns / 1ps

// Pairs note on / note off requests into completed notes and damper press /
// release requests into damper spans. Every request adds its delta to a
// 32-bit running tick that saturates at all ones; times come out as whole
// ticks (beat scale left to the consumer). A note off gives one result
// with pitch, velocity, start and stop tick; a damper release gives one
// span result; a note on for an already open pitch overwrites it quietly.
// Any error (off without on, lift without press, bad damper request) gives
// one error result and the block then swallows every request until reset.
// Rate: the front takes a request every cycle while its two-entry queue has
// room; the back end handles each request as a pitch table read, then update
// and result, and pops the next one only after the last has committed, which
// waits while the result register is still full. rsp_valid rises after the
// request has passed the queue slot, the work and the result registers. No
// clearing pass: open flags are flip-flops that reset clears at once.

module midi_note_pairing #(
   parameter int PITCH_COUNT = 128
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [27:0] req_delta_ticks,
   input  logic [6:0]  req_pitch_or_pedal,
   input  logic [6:0]  req_velocity,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_note_pitch,
   output logic [6:0]  rsp_note_velocity,
   output logic [31:0] rsp_start_tick,
   output logic [31:0] rsp_stop_tick
);
   import mnp_pkg::*;

   // front to queue
   logic       push_valid;
   logic       push_ready;
   event_type  push_evt;
   // queue to back
   logic       pop_valid;
   logic       pop_ready;
   event_type  pop_evt;
   // back result register
   result_type rsp_res;

   // front: tick stamping
   mnp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_delta_ticks    (req_delta_ticks),
      .req_pitch_or_pedal (req_pitch_or_pedal),
      .req_velocity       (req_velocity),
      .push_valid         (push_valid),
      .push_ready         (push_ready),
      .push_evt           (push_evt)
   );

   // decoupling queue
   mnp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_evt   (push_evt),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_evt    (pop_evt)
   );

   // back: pairing against the pitch table and damper record
   mnp_back #(
      .PITCH_COUNT (PITCH_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_evt   (pop_evt),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_res   (rsp_res)
   );

   // result fields out to ports
   assign rsp_status        = rsp_res.status;
   assign rsp_note_pitch    = rsp_res.pitch;
   assign rsp_note_velocity = rsp_res.vel;
   assign rsp_start_tick    = rsp_res.start;
   assign rsp_stop_tick     = rsp_res.stop;

endmodule

// ===== bench/midi_note_pairing_test.sv =====
// midi_note_pairing_test: self-checking bench for the midi note pairing block
// drives random and directed requests, predicts each result and compares it
// depends on mnp_pkg and midi_note_pairing
`timescale 1ns / 1ps

module midi_note_pairing_test;

   import mnp_pkg::*;

   // mode code that the block only uses to advance the tick
   localparam logic [1:0] ModeSpare = 2'd3;
   localparam int PitchCount = 128;
   // random requests between the directed opening and the closing phases
   localparam int RandomItems = 1560;
   // once fewer requests than this are left, neither side stalls at random
   localparam int TailItems = 150;
   localparam logic [27:0] DeltaMax = 28'hFFF_FFFF;

   // one request waiting to be driven; drain holds it back until every
   // expected result has come out
   typedef struct {
      logic [1:0]  mode;
      logic [27:0] delta;
      logic [6:0]  pv;
      logic [6:0]  vel;
      bit          drain;
   } midi_event_type;

   // one entry of the predicted pitch table
   typedef struct packed {
      logic        open;
      logic [6:0]  vel;
      logic [31:0] start;
   } note_slot_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = '0;
   logic [27:0] req_delta_ticks = '0;
   logic [6:0]  req_pitch_or_pedal = '0;
   logic [6:0]  req_velocity = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [6:0]  rsp_note_pitch;
   logic [6:0]  rsp_note_velocity;
   logic [31:0] rsp_start_tick;
   logic [31:0] rsp_stop_tick;

   midi_note_pairing #(
      .PITCH_COUNT(PitchCount)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_delta_ticks   (req_delta_ticks),
      .req_pitch_or_pedal(req_pitch_or_pedal),
      .req_velocity      (req_velocity),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_note_pitch    (rsp_note_pitch),
      .rsp_note_velocity (rsp_note_velocity),
      .rsp_start_tick    (rsp_start_tick),
      .rsp_stop_tick     (rsp_stop_tick)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // predicted block state
   // ------------------------------------------------------------------
   note_slot_type note_table [PitchCount];
   logic [31:0]   tick_now;
   logic          damper_down;
   logic [31:0]   damper_start;
   logic          stuck;

   // completed notes, damper spans and error results still to come out
   result_type  expected_spans [$];
   int          mismatch_count = 0;

   // what the generator believes is open, so that the random part stays legal
   midi_event_type midi_events [$];
   bit             gen_open [PitchCount];
   int             open_pitches [$];
   bit             gen_pedal;
   bit             hold_next;

   // handshake bookkeeping between driver and monitor
   bit             req_taken = 1'b0;
   bit             req_busy = 1'b0;
   bit             quiet_tail = 1'b0;
   int             req_gap_left = 0;
   int             req_calm_left = 0;
   int             rsp_stall_left = 0;
   int             rsp_calm_left = 0;
   int             req_roll;
   int             rsp_roll;
   midi_event_type next_event;
   result_type     want;

   // queue an error result and freeze, as the block does on any error
   task automatic raise_error(input logic [2:0] code);
      result_type span;
      span = '{status: code, pitch: '0, vel: '0, start: '0, stop: '0};
      expected_spans.insert(expected_spans.size(), span);
      stuck = 1'b1;
   endtask

   // advance the tick and pair one accepted request against the open notes
   task automatic pair_event(input logic [1:0] mode, input logic [27:0] delta,
                             input logic [6:0] pv, input logic [6:0] vel);
      result_type span;
      logic [31:0] step;
      step = {4'b0, delta};
      if (stuck) return;
      // saturate at all ones instead of wrapping
      if (tick_now > TickMax - step) tick_now = TickMax;
      else tick_now = tick_now + step;
      case (mode)
         ModeNoteOn: begin
            // a second note on for an open pitch simply overwrites it
            if (int'(pv) < PitchCount) note_table[pv] = '{1'b1, vel, tick_now};
         end
         ModeNoteOff: begin
            if (int'(pv) >= PitchCount || !note_table[pv].open) begin
               raise_error(StatusOffNoOn);
            end else begin
               note_table[pv].open = 1'b0;
               span = '{status: StatusNoteDone, pitch: pv, vel: note_table[pv].vel,
                        start: note_table[pv].start, stop: tick_now};
               expected_spans.insert(expected_spans.size(), span);
            end
         end
         ModeDamper: begin
            if (pv == PedalRelease && !damper_down) begin
               raise_error(StatusLiftNoPress);
            end else if (pv == PedalPress && !damper_down) begin
               damper_down = 1'b1;
               damper_start = tick_now;
            end else if (pv == PedalRelease && damper_down) begin
               damper_down = 1'b0;
               span = '{status: StatusDamperDone, pitch: '0, vel: '0,
                        start: damper_start, stop: tick_now};
               expected_spans.insert(expected_spans.size(), span);
            end else begin
               // press while pressed, or a pedal value above one
               raise_error(StatusBadDamper);
            end
         end
         default: begin
            // spare mode only moves the tick
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   // ------------------------------------------------------------------
   // stimulus generation
   // ------------------------------------------------------------------
   task automatic queue_event(input logic [1:0] mode, input logic [27:0] delta,
                              input logic [6:0] pv, input logic [6:0] vel);
      midi_event_type ev;
      ev = '{mode: mode, delta: delta, pv: pv, vel: vel, drain: hold_next};
      hold_next = 1'b0;
      midi_events.insert(midi_events.size(), ev);
      // keep the generator's view of open notes and pedal in step
      if (mode == ModeNoteOn && !gen_open[pv]) begin
         gen_open[pv] = 1'b1;
         open_pitches.insert(open_pitches.size(), int'(pv));
      end else if (mode == ModeNoteOff && gen_open[pv]) begin
         gen_open[pv] = 1'b0;
         foreach (open_pitches[k]) begin
            if (open_pitches[k] == int'(pv)) begin
               open_pitches.delete(k);
               break;
            end
         end
      end else if (mode == ModeDamper) begin
         if (pv == PedalPress) gen_pedal = 1'b1;
         else if (pv == PedalRelease) gen_pedal = 1'b0;
      end
   endtask

   function automatic logic [6:0] random_vel();
      return 7'($urandom_range(0, 127));
   endfunction

   // mostly short gaps, some zero, now and then a huge jump
   function automatic logic [27:0] random_delta();
      int roll;
      roll = $urandom_range(0, 999);
      if (roll < 4) return 28'($urandom_range(0, DeltaMax));
      if (roll < 150) return '0;
      return 28'($urandom_range(1, 2000));
   endfunction

   // half the note ons land in a narrow band so pitches get reused
   function automatic logic [6:0] random_pitch();
      if ($urandom_range(0, 1) == 0) return 7'($urandom_range(0, 127));
      return 7'($urandom_range(56, 71));
   endfunction

   // close one of the open notes at random
   task automatic queue_random_off(input logic [27:0] delta);
      int idx;
      idx = $urandom_range(0, open_pitches.size() - 1);
      queue_event(ModeNoteOff, delta, 7'(open_pitches[idx]), random_vel());
   endtask

   task automatic build_directed();
      // pitch and velocity extremes, largest delta straight away
      queue_event(ModeNoteOn, '0, 7'd0, 7'd127);
      queue_event(ModeNoteOn, DeltaMax, 7'd127, 7'd0);
      queue_event(ModeNoteOn, 28'd1, 7'h55, 7'h2a);
      queue_event(ModeNoteOn, 28'd100, 7'h2a, 7'h55);
      queue_event(ModeNoteOff, 28'd5, 7'd127, 7'd127);
      // note on over an open pitch replaces it quietly
      queue_event(ModeNoteOn, 28'd3, 7'd0, 7'd1);
      queue_event(ModeNoteOff, '0, 7'd0, 7'd0);
      queue_event(ModeDamper, 28'd7, PedalPress, 7'd127);
      queue_event(ModeSpare, 28'haaa_aaaa, 7'd127, 7'd127);
      queue_event(ModeDamper, 28'h555_5555, PedalRelease, 7'd0);
      queue_event(ModeNoteOff, 28'd9, 7'h55, 7'd0);
      queue_event(ModeNoteOff, '0, 7'h2a, 7'd0);
      // replace then close with zero deltas: start equals stop
      queue_event(ModeNoteOn, 28'd64, 7'd60, 7'd64);
      queue_event(ModeNoteOn, '0, 7'd60, 7'd100);
      queue_event(ModeNoteOff, '0, 7'd60, 7'd1);
      queue_event(ModeDamper, '0, PedalPress, 7'd0);
      queue_event(ModeDamper, '0, PedalRelease, 7'd0);
      queue_event(ModeSpare, '0, 7'd0, 7'd0);
   endtask

   task automatic build_random();
      int roll;
      logic [27:0] delta;
      for (int n = 0; n < RandomItems; n++) begin
         // make the sender wait for an empty pipe once in the middle
         if (n == RandomItems / 2) hold_next = 1'b1;
         roll = $urandom_range(0, 99);
         delta = random_delta();
         if (roll < 8) begin
            queue_event(ModeSpare, delta, 7'($urandom_range(0, 127)), random_vel());
         end else if (roll < 20) begin
            queue_event(ModeDamper, delta, gen_pedal ? PedalRelease : PedalPress,
                        random_vel());
         end else if ((roll < 58 || open_pitches.size() > 24) && open_pitches.size() > 0) begin
            queue_random_off(delta);
         end else begin
            queue_event(ModeNoteOn, delta, random_pitch(), random_vel());
         end
      end
   endtask

   // drive the tick into saturation, then end with one error and the halt
   task automatic build_closing();
      int kind;
      logic [6:0] spare_pitch;
      hold_next = 1'b1;
      if (gen_pedal) queue_event(ModeDamper, 28'd11, PedalRelease, random_vel());
      queue_event(ModeNoteOn, 28'd2, 7'd10, random_vel());
      queue_event(ModeDamper, 28'd2, PedalPress, random_vel());
      repeat (17) queue_event(ModeSpare, DeltaMax, random_vel(), random_vel());
      while (open_pitches.size() > 0) queue_random_off(random_delta());
      queue_event(ModeDamper, DeltaMax, PedalRelease, random_vel());
      // a note begun after saturation starts and stops at the top
      queue_event(ModeNoteOn, 28'd5, 7'd33, 7'd99);
      queue_event(ModeNoteOff, 28'd5, 7'd33, 7'd0);
      queue_event(ModeDamper, '0, PedalPress, 7'd0);
      queue_event(ModeDamper, '0, PedalRelease, 7'd0);
      // all notes are closed and the pedal is up here
      kind = $urandom_range(0, 3);
      case (kind)
         0: queue_event(ModeNoteOff, random_delta(), random_pitch(), random_vel());
         1: queue_event(ModeDamper, random_delta(), PedalRelease, random_vel());
         2: begin
            queue_event(ModeDamper, random_delta(), PedalPress, random_vel());
            queue_event(ModeDamper, random_delta(), PedalPress, random_vel());
         end
         default: begin
            spare_pitch = 7'($urandom_range(2, 127));
            queue_event(ModeDamper, random_delta(), spare_pitch, random_vel());
         end
      endcase
      // halted: these must all be swallowed without a result
      queue_event(ModeNoteOn, 28'd1, 7'd20, 7'd20);
      queue_event(ModeNoteOff, 28'd1, 7'd20, 7'd20);
      queue_event(ModeDamper, 28'd1, PedalPress, 7'd0);
      queue_event(ModeDamper, 28'd1, PedalRelease, 7'd0);
      queue_event(ModeNoteOff, 28'd1, 7'd77, 7'd0);
      queue_event(ModeSpare, DeltaMax, 7'd1, 7'd1);
   endtask

   // ------------------------------------------------------------------
   // request driver: changes inputs at the falling edge only
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_taken) begin
            // the current request went in at the last rising edge
            req_taken = 1'b0;
            req_busy = 1'b0;
            quiet_tail = midi_events.size() < TailItems;
            if (quiet_tail) begin
               req_gap_left = 0;
            end else if (req_calm_left > 0) begin
               req_calm_left--;
            end else begin
               req_roll = $urandom_range(0, 99);
               if (req_roll < 25) req_gap_left = $urandom_range(1, 19);
               else if (req_roll < 30) req_calm_left = $urandom_range(20, 80);
            end
         end
         if (!req_busy) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
            end else if (midi_events.size() > 0 &&
                         !(midi_events[0].drain && expected_spans.size() != 0)) begin
               next_event = midi_events.pop_front();
               req_mode <= next_event.mode;
               req_delta_ticks <= next_event.delta;
               req_pitch_or_pedal <= next_event.pv;
               req_velocity <= next_event.vel;
               req_busy = 1'b1;
            end
         end
         // valid stays up with the same payload until the request is taken
         req_valid <= req_busy;
      end
   end

   // result side back-pressure: random stall bursts and calm stretches
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (quiet_tail) begin
         rsp_ready <= 1'b1;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_calm_left > 0) begin
         rsp_calm_left--;
         rsp_ready <= 1'b1;
      end else begin
         rsp_roll = $urandom_range(0, 99);
         if (rsp_roll < 15) begin
            rsp_stall_left = $urandom_range(1, 19) - 1;
            rsp_ready <= 1'b0;
         end else begin
            if (rsp_roll < 19) rsp_calm_left = $urandom_range(20, 100);
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // monitor: samples both channels at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            pair_event(req_mode, req_delta_ticks, req_pitch_or_pedal, req_velocity);
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_spans.size() == 0) begin
               $error("result with nothing pending, status %0d", rsp_status);
               mismatch_count++;
            end else begin
               want = expected_spans.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("note_pitch", 32'(want.pitch), 32'(rsp_note_pitch));
               check_field("note_velocity", 32'(want.vel), 32'(rsp_note_velocity));
               check_field("start_tick", want.start, rsp_start_tick);
               check_field("stop_tick", want.stop, rsp_stop_tick);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // run control
   // ------------------------------------------------------------------
   initial begin
      // predictor starts from the reset state
      foreach (note_table[i]) note_table[i] = '0;
      foreach (gen_open[i]) gen_open[i] = 1'b0;
      tick_now = '0;
      damper_down = 1'b0;
      damper_start = '0;
      stuck = 1'b0;
      gen_pedal = 1'b0;
      hold_next = 1'b0;
      build_directed();
      build_random();
      build_closing();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every request in, then every result out, then a short quiet tail
      while (midi_events.size() != 0 || req_busy) @(posedge clock);
      while (expected_spans.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_spans.size() != 0) begin
         $error("%0d results never came out", expected_spans.size());
         mismatch_count++;
      end

      if (mismatch_count == 0) begin
         $display("midi_note_pairing_test OK");
      end else begin
         $display("midi_note_pairing_test NOT OK");
      end
      $finish;
   end

   // watchdog against a hung handshake
   initial begin
      #4_000_000;
      $display("midi_note_pairing_test NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/mnp_pkg.sv
hw/rtl/mnp_front.sv
hw/rtl/mnp_queue.sv
hw/rtl/mnp_back.sv
hw/rtl/midi_note_pairing.sv
bench/midi_note_pairing_test.sv
